// ===== design/lplr_pkg.sv =====
// lplr_pkg: shared types and constants for the length-prefixed line receiver
// used by the channel interfaces, the step logic and the top level
// no dependencies
package lplr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned STAT_W = 4;

  localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'd64;

  // character codes
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

  // opcodes of an input beat
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DIGIT    = 4'd0,
    ST_LENDONE  = 4'd1,
    ST_PAYLOAD  = 4'd2,
    ST_DONE     = 4'd3,
    ST_BLANK    = 4'd4,
    ST_BADCHAR  = 4'd5,
    ST_TOOLONG  = 4'd6,
    ST_EMPTY    = 4'd7,
    ST_OVERFLOW = 4'd8,
    ST_IGNORED  = 4'd9,
    ST_RESTART  = 4'd10
  } status_t;

  // receiver stage, one-hot
  typedef enum logic [2:0] {
    STG_LEN = 3'b001,
    STG_STR = 3'b010,
    STG_FIN = 3'b100
  } stage_t;

  typedef struct packed {
    stage_t             stage;
    logic [LEN_W-1:0]   declared_len;
    logic [LEN_W-1:0]   received_cnt;
  } rx_state_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  payload_byte;
    logic [LEN_W-1:0]   position;
    logic [LEN_W-1:0]   count;
  } rx_result_t;

endpackage

// ===== design/lplr_in_if.sv =====
// lplr_in_if: input byte channel (valid/ready with opcode and data byte)
// depends on lplr_pkg
interface lplr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [lplr_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

// ===== design/lplr_out_if.sv =====
// lplr_out_if: result channel (valid/ready with status, byte, position, count)
// depends on lplr_pkg
interface lplr_out_if;
  logic                        valid;
  logic                        ready;
  logic [lplr_pkg::STAT_W-1:0] status;
  logic [lplr_pkg::BYTE_W-1:0] payload_byte;
  logic [lplr_pkg::LEN_W-1:0]  position;
  logic [lplr_pkg::LEN_W-1:0]  count;

  modport source (output valid, output status, output payload_byte,
                  output position, output count, input ready);
  modport sink   (input valid, input status, input payload_byte,
                  input position, input count, output ready);
endinterface

// ===== design/lplr_cfg_if.sv =====
// lplr_cfg_if: configuration write channel carrying max_len
// depends on lplr_pkg
interface lplr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lplr_pkg::LEN_W-1:0] max_len;

  modport source (output valid, output max_len, input ready);
  modport sink   (input valid, input max_len, output ready);
endinterface

// ===== design/lplr_step.sv =====
// lplr_step: next-state and result logic for one input beat
// depends on lplr_pkg
module lplr_step (
  input  logic                         opcode,
  input  logic [lplr_pkg::BYTE_W-1:0]  data_byte,
  input  logic [lplr_pkg::LEN_W-1:0]   max_len,
  input  lplr_pkg::rx_state_t          cur,
  output lplr_pkg::rx_state_t          nxt,
  output lplr_pkg::rx_result_t         res
);
  import lplr_pkg::*;

  localparam int unsigned ACC_W = LEN_W + 4;

  logic              is_break;
  logic              is_digit;
  logic [ACC_W-1:0]  len_x10;
  logic [ACC_W-1:0]  len_acc;
  logic [LEN_W:0]    rcv_inc;
  rx_state_t         restart_st;

  // byte classification
  assign is_break = (data_byte == CH_CR) || (data_byte == CH_LF);
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

  // decimal accumulate: len * 10 + digit, wide enough to see overflow
  assign len_x10 = {cur.declared_len, 3'b000} + {3'b000, cur.declared_len, 1'b0};
  assign len_acc = len_x10 + ACC_W'(data_byte - CH_ZERO);
  assign rcv_inc = {1'b0, cur.received_cnt} + (LEN_W+1)'(1);

  assign restart_st = '{stage: STG_LEN, declared_len: '0, received_cnt: '0};

  always_comb begin
    nxt              = cur;
    res.status       = ST_IGNORED;
    res.payload_byte = '0;
    res.position     = '0;
    res.count        = '0;
    if (opcode == OP_RESTART) begin
      nxt        = restart_st;
      res.status = ST_RESTART;
    end else begin
      case (cur.stage)
        // length line
        STG_LEN: begin
          if (cur.declared_len > max_len) begin
            nxt        = restart_st;
            res.status = ST_TOOLONG;
          end else if (is_break) begin
            if (cur.declared_len == '0) begin
              nxt        = restart_st;
              res.status = ST_EMPTY;
            end else begin
              nxt.stage  = STG_STR;
              res.count  = cur.declared_len;
              res.status = ST_LENDONE;
            end
          end else if (!is_digit) begin
            nxt.declared_len = '0;
            res.status       = ST_BADCHAR;
          end else if (len_acc[ACC_W-1:LEN_W] != '0) begin
            nxt.declared_len = '0;
            res.status       = ST_OVERFLOW;
          end else begin
            nxt.declared_len = len_acc[LEN_W-1:0];
            res.status       = ST_DIGIT;
          end
        end
        // payload line
        STG_STR: begin
          if (is_break) begin
            if (cur.received_cnt == '0) begin
              res.status = ST_BLANK;
            end else begin
              nxt.stage  = STG_FIN;
              res.count  = cur.received_cnt;
              res.status = ST_DONE;
            end
          end else if (rcv_inc > {1'b0, cur.declared_len}) begin
            nxt        = restart_st;
            res.status = ST_TOOLONG;
          end else begin
            res.payload_byte = data_byte;
            res.position     = cur.received_cnt;
            nxt.received_cnt = rcv_inc[LEN_W-1:0];
            res.status       = ST_PAYLOAD;
          end
        end
        default: begin
          res.status = ST_IGNORED;
        end
      endcase
    end
  end

endmodule

// ===== design/length_prefixed_line_receiver_top.sv =====
// length_prefixed_line_receiver_top: length-prefixed line receiver top level
// depends on lplr_pkg, lplr_in_if, lplr_out_if, lplr_cfg_if and lplr_step
//
// usage:
//   in_ch carries one beat per received serial byte (opcode 0) or a restart
//   request (opcode 1). every accepted beat yields exactly one result beat on
//   out_ch: status, plus the payload byte and its position for payload bytes,
//   and the parsed or final length in count for the two line-end statuses.
//   cfg_ch writes max_len; it is always ready and should only be written
//   while no beat is in flight.
// pipeline and throughput:
//   a beat lands in the input register, is decoded combinationally against the
//   receiver state and lands in the result register. one beat per cycle is
//   sustained while out_ch.ready stays high, set by the single decode step
//   between the two registers.
// reset:
//   rst_n is synchronous, active low; it empties both registers, returns the
//   receiver to the length stage with zero counts and sets max_len to 64.
// stalls:
//   while out_ch.ready is low a full result register holds; the input register
//   still takes one more beat, after which in_ch.ready drops. no beat is lost.
module length_prefixed_line_receiver_top (
  input  logic       clk,
  input  logic       rst_n,
  lplr_in_if.sink    in_ch,
  lplr_out_if.source out_ch,
  lplr_cfg_if.sink   cfg_ch
);
  import lplr_pkg::*;

  logic                 in_vld_r;
  logic                 in_op_r;
  logic [BYTE_W-1:0]    in_byte_r;
  logic                 out_vld_r;
  rx_result_t           res_r;
  rx_result_t           res_nxt;
  rx_state_t            st_r;
  rx_state_t            st_nxt;
  logic [LEN_W-1:0]     max_len_r;
  logic                 advance;
  logic                 in_take;

  // handshake
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_ch.valid) begin
      max_len_r <= cfg_ch.max_len;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r   <= in_ch.opcode;
      in_byte_r <= in_ch.data_byte;
    end
  end

  // decode step
  lplr_step u_step (
    .opcode    (in_op_r),
    .data_byte (in_byte_r),
    .max_len   (max_len_r),
    .cur       (st_r),
    .nxt       (st_nxt),
    .res       (res_nxt)
  );

  // receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{stage: STG_LEN, declared_len: '0, received_cnt: '0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.payload_byte = res_r.payload_byte;
  assign out_ch.position     = res_r.position;
  assign out_ch.count        = res_r.count;

  // checks
  a_stage_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r.stage))
    else $error("receiver stage lost its one-hot code");

  a_payload_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.stage == STG_STR) |-> (st_r.declared_len != '0))
    else $error("payload stage entered with a zero length");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.received_cnt <= st_r.declared_len)
    else $error("payload count ran past the declared length");

  a_len_stage_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.stage == STG_LEN) |-> (st_r.received_cnt == '0))
    else $error("payload count nonzero in the length stage");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_op_r == OP_RESTART) |=>
      (st_r.stage == STG_LEN && out_vld_r && res_r.status == ST_RESTART))
    else $error("restart beat did not reset the receiver");

endmodule
